>>> design/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants shared by the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned MEM_BYTES_DEF = 65536;
  localparam int unsigned HDR_BYTES     = 4;
  localparam int unsigned HEAP_RESET    = 32;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned HEAP_W  = 17;
  localparam int unsigned PADDR_W = 3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic REG_INITIAL_HEAP = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OOM       = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MODE_ALLOC,
    MODE_FREE_HEAD,
    MODE_FREE_WALK,
    MODE_FREE_UNLINK
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_FREE,
    ST_READ,
    ST_EVAL,
    ST_PLACE_CHK,
    ST_GROW,
    ST_WR_HDR,
    ST_WR_LINK,
    ST_DONE
  } state_e;

endpackage

>>> design/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator keeping an address-ordered block chain in byte memory.
// ----------------------------------------------------------------------------
// Requests enter on the in channel (cmd_i, request_size_i, block_address_i)
// and are taken when in_valid_i is high and in_stall_o is low. Each request
// gives exactly one result on the out channel (result_address_o, status_o,
// heap_bound_o), taken when out_valid_o is high and out_stall_i is low.
// One request is worked at a time by a sequencer around a byte-wide memory
// (one write port, one registered read port), so the cost follows the number
// of chain blocks visited. Each visited header is read a byte at a time and
// then evaluated. An allocate walks the chain to the first fitting gap or its
// end, checks that the block fits in memory, doubles the heap bound as needed,
// writes the header and then the link (the link write is skipped when placing
// at address 0). A free walks the chain, then unlinks the block or moves the head.
// A finished result sits in the output register; the next request is taken
// while it waits, and a later result is held in the sequencer until the
// output register is free. Reset empties the chain and sets the heap bound
// to 32 bytes; block memory is not cleared and needs no clearing pass.
// The APB port holds initial_heap_bytes at address 0; a write also reloads
// the heap bound.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
  parameter int unsigned MEM_BYTES = ffba_pkg::MEM_BYTES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cmd_i,
  input  logic [ffba_pkg::FIELD_W-1:0]        request_size_i,
  input  logic [ffba_pkg::FIELD_W-1:0]        block_address_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ffba_pkg::FIELD_W-1:0]        result_address_o,
  output logic [1:0]                          status_o,
  output logic [ffba_pkg::HEAP_W-1:0]         heap_bound_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ffba_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam logic [17:0] MemBytes18 = 18'(MEM_BYTES);
  localparam logic [16:0] MemBytes17 = 17'(MEM_BYTES);
  localparam logic [16:0] HdrBytes17 = 17'(ffba_pkg::HDR_BYTES);

  function automatic logic [AW-1:0] wrap_addr(input logic [17:0] a);
    logic [17:0] r;
    r = (a >= MemBytes18) ? a - MemBytes18 : a;
    return r[AW-1:0];
  endfunction

  ffba_pkg::state_e state_q, state_d;
  ffba_pkg::mode_e  mode_q, mode_d;

  logic        cmd_q, cmd_d;
  logic [15:0] size_q, size_d;
  logic [15:0] addr_q, addr_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] rd_base_q, rd_base_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] hdr_q, hdr_d;
  logic [16:0] place_addr_q, place_addr_d;
  logic [15:0] place_next_q, place_next_d;
  logic        link_pend_q, link_pend_d;
  logic [17:0] need_q, need_d;
  logic [15:0] link_val_q, link_val_d;
  logic [15:0] res_addr_q, res_addr_d;
  logic [1:0]  res_status_q, res_status_d;
  logic [15:0] head_q, head_d;
  logic        nonempty_q, nonempty_d;
  logic [16:0] heap_q, heap_d;
  logic [16:0] init_q, init_d;

  logic        out_valid_q, out_valid_d;
  logic [15:0] out_addr_q, out_addr_d;
  logic [1:0]  out_status_q, out_status_d;
  logic [16:0] out_heap_q, out_heap_d;

  logic [7:0]    mem [MEM_BYTES];
  logic [7:0]    rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_wdata;

  logic        cfg_we;
  logic [16:0] cfg_val;
  logic        in_accept;
  logic [17:0] head_gap;
  logic [16:0] blk_end;
  logic [19:0] gap_fit;
  logic [17:0] heap_dbl;
  logic [31:0] hdr_wr;
  logic [1:0]  rd_byte;

  assign pready     = 1'b1;
  assign cfg_we     = psel && penable && pwrite && pready &&
                      (paddr[2] == ffba_pkg::REG_INITIAL_HEAP);
  assign prdata     = (paddr[2] == ffba_pkg::REG_INITIAL_HEAP) ? {15'd0, init_q} : 32'd0;
  assign in_stall_o = (state_q != ffba_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign out_valid_o      = out_valid_q;
  assign result_address_o = out_addr_q;
  assign status_o         = out_status_q;
  assign heap_bound_o     = out_heap_q;

  always_comb begin
    if (pwdata[15:0] < 16'(ffba_pkg::HDR_BYTES)) begin
      cfg_val = HdrBytes17;
    end else if ({1'b0, pwdata[15:0]} > MemBytes17) begin
      cfg_val = MemBytes17;
    end else begin
      cfg_val = {1'b0, pwdata[15:0]};
    end
  end

  assign head_gap = {2'b00, head_q} - {2'b00, size_q};
  assign blk_end  = {1'b0, pos_q} + {1'b0, hdr_q[15:0]};
  assign gap_fit  = {4'd0, hdr_q[31:16]} - {4'd0, size_q} - {3'd0, blk_end};
  assign heap_dbl = {heap_q, 1'b0};
  assign hdr_wr   = {place_next_q, size_q + 16'(ffba_pkg::HDR_BYTES)};
  assign rd_byte  = cnt_q[1:0] - 2'd1;

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    cmd_d        = cmd_q;
    size_d       = size_q;
    addr_d       = addr_q;
    pos_d        = pos_q;
    rd_base_d    = rd_base_q;
    cnt_d        = cnt_q;
    hdr_d        = hdr_q;
    place_addr_d = place_addr_q;
    place_next_d = place_next_q;
    link_pend_d  = link_pend_q;
    need_d       = need_q;
    link_val_d   = link_val_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    head_d       = head_q;
    nonempty_d   = nonempty_q;
    heap_d       = heap_q;
    init_d       = init_q;
    out_valid_d  = out_valid_q;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;
    out_heap_d   = out_heap_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = 8'd0;
    mem_raddr    = wrap_addr({2'b00, rd_base_q} + {15'd0, cnt_q});

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we) begin
      init_d = cfg_val;
      heap_d = cfg_val;
    end

    case (state_q)
      ffba_pkg::ST_IDLE: begin
        if (in_accept) begin
          cmd_d        = cmd_i;
          size_d       = request_size_i;
          addr_d       = block_address_i;
          res_addr_d   = 16'd0;
          res_status_d = ffba_pkg::STATUS_OK;
          state_d      = (cmd_i == ffba_pkg::CMD_FREE) ? ffba_pkg::ST_FREE
                                                       : ffba_pkg::ST_ALLOC;
        end
      end
      ffba_pkg::ST_ALLOC: begin
        if (!nonempty_q || ($signed(head_gap) >= 18'sd4)) begin
          place_addr_d = 17'd0;
          place_next_d = nonempty_q ? head_q : 16'd0;
          link_pend_d  = 1'b0;
          state_d      = ffba_pkg::ST_PLACE_CHK;
        end else begin
          pos_d     = head_q;
          rd_base_d = head_q;
          cnt_d     = 3'd0;
          mode_d    = ffba_pkg::MODE_ALLOC;
          state_d   = ffba_pkg::ST_READ;
        end
      end
      ffba_pkg::ST_FREE: begin
        cnt_d     = 3'd0;
        pos_d     = head_q;
        rd_base_d = head_q;
        if (!nonempty_q) begin
          res_status_d = ffba_pkg::STATUS_NOT_FOUND;
          state_d      = ffba_pkg::ST_DONE;
        end else if (head_q == addr_q) begin
          mode_d  = ffba_pkg::MODE_FREE_HEAD;
          state_d = ffba_pkg::ST_READ;
        end else begin
          mode_d  = ffba_pkg::MODE_FREE_WALK;
          state_d = ffba_pkg::ST_READ;
        end
      end
      ffba_pkg::ST_READ: begin
        if (cnt_q != 3'd0) begin
          hdr_d[8*rd_byte +: 8] = rdata_q;
        end
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          cnt_d   = 3'd0;
          state_d = ffba_pkg::ST_EVAL;
        end
      end
      ffba_pkg::ST_EVAL: begin
        cnt_d = 3'd0;
        case (mode_q)
          ffba_pkg::MODE_ALLOC: begin
            if (hdr_q[31:16] <= pos_q) begin
              place_addr_d = blk_end;
              place_next_d = 16'd0;
              link_pend_d  = 1'b1;
              state_d      = ffba_pkg::ST_PLACE_CHK;
            end else if ($signed(gap_fit) >= 20'sd4) begin
              place_addr_d = blk_end;
              place_next_d = hdr_q[31:16];
              link_pend_d  = 1'b1;
              state_d      = ffba_pkg::ST_PLACE_CHK;
            end else begin
              pos_d     = hdr_q[31:16];
              rd_base_d = hdr_q[31:16];
              state_d   = ffba_pkg::ST_READ;
            end
          end
          ffba_pkg::MODE_FREE_HEAD: begin
            head_d     = hdr_q[31:16];
            nonempty_d = (hdr_q[31:16] != 16'd0);
            state_d    = ffba_pkg::ST_DONE;
          end
          ffba_pkg::MODE_FREE_WALK: begin
            if (hdr_q[31:16] > pos_q) begin
              rd_base_d = hdr_q[31:16];
              state_d   = ffba_pkg::ST_READ;
              if (hdr_q[31:16] == addr_q) begin
                mode_d = ffba_pkg::MODE_FREE_UNLINK;
              end else begin
                pos_d = hdr_q[31:16];
              end
            end else begin
              res_status_d = ffba_pkg::STATUS_NOT_FOUND;
              state_d      = ffba_pkg::ST_DONE;
            end
          end
          ffba_pkg::MODE_FREE_UNLINK: begin
            link_val_d = hdr_q[31:16];
            state_d    = ffba_pkg::ST_WR_LINK;
          end
          default: begin
            state_d = ffba_pkg::ST_DONE;
          end
        endcase
      end
      ffba_pkg::ST_PLACE_CHK: begin
        need_d = {1'b0, place_addr_q} + {2'b00, size_q} + 18'(ffba_pkg::HDR_BYTES);
        if (({1'b0, place_addr_q} + {2'b00, size_q} + 18'(ffba_pkg::HDR_BYTES))
            >= MemBytes18) begin
          res_status_d = ffba_pkg::STATUS_OOM;
          state_d      = ffba_pkg::ST_DONE;
        end else begin
          state_d = ffba_pkg::ST_GROW;
        end
      end
      ffba_pkg::ST_GROW: begin
        cnt_d = 3'd0;
        if (need_q >= {1'b0, heap_q}) begin
          heap_d = (heap_dbl > MemBytes18) ? MemBytes17 : heap_dbl[16:0];
        end else begin
          state_d = ffba_pkg::ST_WR_HDR;
        end
      end
      ffba_pkg::ST_WR_HDR: begin
        mem_we    = 1'b1;
        mem_waddr = wrap_addr({1'b0, place_addr_q} + {15'd0, cnt_q});
        mem_wdata = hdr_wr[8*cnt_q[1:0] +: 8];
        cnt_d     = cnt_q + 3'd1;
        if (cnt_q == 3'd3) begin
          cnt_d = 3'd0;
          if (link_pend_q) begin
            link_val_d = place_addr_q[15:0];
            res_addr_d = place_addr_q[15:0];
            state_d    = ffba_pkg::ST_WR_LINK;
          end else begin
            head_d     = 16'd0;
            nonempty_d = 1'b1;
            state_d    = ffba_pkg::ST_DONE;
          end
        end
      end
      ffba_pkg::ST_WR_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = wrap_addr({2'b00, pos_q} + 18'd2 + {15'd0, cnt_q});
        mem_wdata = cnt_q[0] ? link_val_q[15:8] : link_val_q[7:0];
        cnt_d     = cnt_q + 3'd1;
        if (cnt_q == 3'd1) begin
          cnt_d   = 3'd0;
          state_d = ffba_pkg::ST_DONE;
        end
      end
      ffba_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_addr_d   = res_addr_q;
          out_status_d = res_status_q;
          out_heap_d   = heap_q;
          state_d      = ffba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ffba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffba_pkg::ST_IDLE;
      head_q      <= 16'd0;
      nonempty_q  <= 1'b0;
      heap_q      <= 17'(ffba_pkg::HEAP_RESET);
      init_q      <= 17'(ffba_pkg::HEAP_RESET);
      out_valid_q <= 1'b0;
      cnt_q       <= 3'd0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      nonempty_q  <= nonempty_d;
      heap_q      <= heap_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    cmd_q        <= cmd_d;
    size_q       <= size_d;
    addr_q       <= addr_d;
    pos_q        <= pos_d;
    rd_base_q    <= rd_base_d;
    hdr_q        <= hdr_d;
    place_addr_q <= place_addr_d;
    place_next_q <= place_next_d;
    link_pend_q  <= link_pend_d;
    need_q       <= need_d;
    link_val_q   <= link_val_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
    out_heap_q   <= out_heap_d;
  end

  a_heap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (heap_q <= MemBytes17) && (heap_q >= HdrBytes17))
    else $error("heap bound out of range");

  a_heap_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) != ffba_pkg::ST_GROW && !$past(cfg_we)) |-> $stable(heap_q))
    else $error("heap bound changed outside growth or config write");

  a_nf_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffba_pkg::ST_DONE && res_status_q == ffba_pkg::STATUS_NOT_FOUND)
    |-> (cmd_q == ffba_pkg::CMD_FREE))
    else $error("not_found on an allocate request");

  a_fail_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ffba_pkg::STATUS_OK) |-> (result_address_o == 16'd0))
    else $error("failed request returned an address");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ffba_pkg::ST_ALLOC || state_q == ffba_pkg::ST_FREE))
    else $error("accepted request did not start");

endmodule
